FILE: rtl/gbr_pkg.sv
package gbr_pkg;

    // image geometry limits
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 16;

    // vertical 1-2-1 sum and full 3x3 sum widths
    localparam int VSUM_W = PIX_W + 2;
    localparam int HSUM_W = VSUM_W + 2;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(2);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    // input item kinds
    typedef enum logic [0:0] {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    // line store write request
    typedef struct packed {
        logic             new_en;
        logic             old_en;
        logic [COL_W-1:0] idx;
        logic [PIX_W-1:0] new_data;
    } t_lb_wr;

    // control carried with an item into the filter stage
    typedef struct packed {
        logic             flush;
        logic             step;
        logic             up_px;
        logic             emit;
        logic             left_self;
        logic             last_col;
        logic             final_row;
        logic [COL_W-1:0] idx;
        logic [PIX_W-1:0] px;
    } t_s1_ctl;

    function automatic logic [VSUM_W-1:0] vsum(
        input logic [PIX_W-1:0] up,
        input logic [PIX_W-1:0] mid,
        input logic [PIX_W-1:0] dn
    );
        vsum = VSUM_W'(up) + {1'b0, mid, 1'b0} + VSUM_W'(dn);
    endfunction

    function automatic logic [PIX_W-1:0] hsum_div16(
        input logic [VSUM_W-1:0] l,
        input logic [VSUM_W-1:0] m,
        input logic [VSUM_W-1:0] r
    );
        logic [HSUM_W-1:0] s;
        s = HSUM_W'(l) + {1'b0, m, 1'b0} + HSUM_W'(r);
        hsum_div16 = s[HSUM_W-1:4];
    endfunction

endpackage

FILE: rtl/gbr_line_buf.sv
module gbr_line_buf
    import gbr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_idx,
    input  t_lb_wr           i_wr,
    output logic [PIX_W-1:0] o_old_q,
    output logic [PIX_W-1:0] o_new_q
);

    logic [PIX_W-1:0] r_older [MAX_WIDTH];
    logic [PIX_W-1:0] r_newer [MAX_WIDTH];
    logic [PIX_W-1:0] r_old_q;
    logic [PIX_W-1:0] r_new_q;

    // registered read of both rows at one column
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_old_q <= r_older[i_rd_idx];
            r_new_q <= r_newer[i_rd_idx];
        end
    end

    // shift the column down: older takes the newer sample read earlier
    always_ff @(posedge i_clk) begin
        if (i_wr.old_en) begin
            r_older[i_wr.idx] <= r_new_q;
        end
        if (i_wr.new_en) begin
            r_newer[i_wr.idx] <= i_wr.new_data;
        end
    end

    assign o_old_q = r_old_q;
    assign o_new_q = r_new_q;

endmodule

FILE: rtl/gaussian_blur_3x3_reflect.sv
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_stall      i_action, i_pixel_in
// result    out        o_out_valid / i_out_stall    o_pixel_out, o_end_of_row,
//                                                   o_end_of_image, o_last_of_run
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one item per cycle while the input is not stalled; a result is registered when its item leaves the filter stage
// the last column of a row gives two results and holds the input while the second one waits
// in the one-entry pending slot behind the single result register
// line store reads are registered at accept, writes land when the item leaves the filter stage
// synchronous active-low reset clears counters, window and valids; line stores stay undefined
// a stalled result holds the filter stage, which then stalls the input
module gaussian_blur_3x3_reflect
    import gbr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_action,
    input  logic [PIX_W-1:0]    i_pixel_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [PIX_W-1:0]    o_pixel_out,
    output logic                o_end_of_row,
    output logic                o_end_of_image,
    output logic                o_last_of_run,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    logic [WIDTH_W-1:0]  r_cfg_width;
    logic [HEIGHT_W-1:0] r_cfg_height;
    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;

    logic [COL_W-1:0]    r_col,   n_col;
    logic [HEIGHT_W-1:0] r_row,   n_row;
    logic [COL_W-1:0]    r_flush, n_flush;
    logic [HEIGHT_W-1:0] row_inc;

    logic                r_s1_valid, n_s1_valid;
    t_s1_ctl             r_s1, n_s1;

    logic [VSUM_W-1:0]   r_win0, r_win1;

    logic                r_out_valid, r_pend_valid;
    logic [PIX_W-1:0]    r_out_pix, r_pend_pix;
    logic                r_out_eor, r_out_eoi, r_out_last;
    logic                r_pend_eoi;

    logic                accept, take, s1_adv, complete;
    logic [COL_W-1:0]    cur_c;
    logic                last_col;
    logic [PIX_W-1:0]    old_q, new_q;
    t_lb_wr              lb_wr;

    logic [PIX_W-1:0]    up_px;
    logic [VSUM_W-1:0]   trip_v, left_v;
    logic [PIX_W-1:0]    res1_pix, res2_pix;

    // configuration writes, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_W'(MAX_WIDTH);
            r_cfg_height <= HEIGHT_W'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    always_comb begin
        if (r_cfg_width < WIDTH_MIN) begin
            eff_w = WIDTH_MIN;
        end else if (r_cfg_width > WIDTH_MAX) begin
            eff_w = WIDTH_MAX;
        end else begin
            eff_w = r_cfg_width;
        end
        eff_h = (r_cfg_height < HEIGHT_MIN) ? HEIGHT_MIN : r_cfg_height;
    end

    // handshakes
    assign take       = r_out_valid && !i_out_stall;
    assign s1_adv     = r_s1_valid && (!r_out_valid || (take && !r_pend_valid));
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    // raster counters and filter stage load
    always_comb begin
        complete   = (r_row >= eff_h);
        cur_c      = (t_action'(i_action) == ACT_FLUSH) ? r_flush : r_col;
        last_col   = ((WIDTH_W'(cur_c) + WIDTH_W'(1)) >= eff_w);
        row_inc    = r_row + HEIGHT_W'(1);
        n_col      = r_col;
        n_row      = r_row;
        n_flush    = r_flush;
        n_s1_valid = s1_adv ? 1'b0 : r_s1_valid;
        n_s1       = r_s1;
        if (accept) begin
            n_s1.px        = i_pixel_in;
            n_s1.idx       = cur_c;
            n_s1.last_col  = last_col;
            n_s1.emit      = (cur_c != '0);
            n_s1.left_self = (cur_c == COL_W'(1));
            n_s1.up_px     = (r_row == HEIGHT_W'(1));
            if (t_action'(i_action) == ACT_PIXEL && !complete) begin
                n_s1_valid      = 1'b1;
                n_s1.flush      = 1'b0;
                n_s1.step       = (r_row != '0);
                n_s1.final_row  = 1'b0;
                if (last_col) begin
                    n_col = '0;
                    if (row_inc >= eff_h || row_inc == '0) begin
                        n_row = eff_h;
                    end else begin
                        n_row = row_inc;
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end else if (t_action'(i_action) == ACT_FLUSH && complete) begin
                n_s1_valid      = 1'b1;
                n_s1.flush      = 1'b1;
                n_s1.step       = 1'b1;
                n_s1.final_row  = 1'b1;
                if (last_col) begin
                    n_flush = '0;
                    n_col   = '0;
                    n_row   = '0;
                end else begin
                    n_flush = r_flush + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_flush    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_flush    <= n_flush;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // line stores
    always_comb begin
        lb_wr.new_en   = s1_adv && !r_s1.flush;
        lb_wr.old_en   = s1_adv && !r_s1.flush && r_s1.step;
        lb_wr.idx      = r_s1.idx;
        lb_wr.new_data = r_s1.px;
    end

    gbr_line_buf u_line_buf (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_idx (cur_c),
        .i_wr     (lb_wr),
        .o_old_q  (old_q),
        .o_new_q  (new_q)
    );

    // column vertical sum and the two possible results
    always_comb begin
        up_px    = r_s1.up_px ? r_s1.px : old_q;
        if (r_s1.flush) begin
            trip_v = vsum(old_q, new_q, old_q);
        end else begin
            trip_v = vsum(up_px, new_q, r_s1.px);
        end
        left_v   = r_s1.left_self ? trip_v : r_win1;
        res1_pix = hsum_div16(left_v, r_win0, trip_v);
        res2_pix = hsum_div16(r_win0, trip_v, r_win0);
    end

    // horizontal window of vertical sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
        end else if (s1_adv && r_s1.step) begin
            r_win1 <= r_win0;
            r_win0 <= trip_v;
        end
    end

    // result register with one pending slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid  <= r_s1.step && r_s1.emit;
            r_pend_valid <= r_s1.step && r_s1.emit && r_s1.last_col;
        end else if (take) begin
            r_out_valid  <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix  <= res1_pix;
            r_out_eor  <= 1'b0;
            r_out_eoi  <= 1'b0;
            r_out_last <= !r_s1.last_col;
            r_pend_pix <= res2_pix;
            r_pend_eoi <= r_s1.final_row;
        end else if (take) begin
            r_out_pix  <= r_pend_pix;
            r_out_eor  <= 1'b1;
            r_out_eoi  <= r_pend_eoi;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_out    = r_out_pix;
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_image = r_out_eoi;
    assign o_last_of_run  = r_out_last;

`ifndef SYNTHESIS
    a_pend_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("pending result without a presented result");

    a_eoi_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_image) |-> o_end_of_row)
        else $error("end of image not on end of row");

    a_eor_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_row) |-> o_last_of_run)
        else $error("end of row not last of run");

    a_pend_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && take) |=> (r_out_valid && !r_pend_valid && r_out_eor))
        else $error("pending result not moved to output");
`endif

endmodule
